@@ sv/rgb_to_hsv_pixel_core_assert.svh @@
// Assertion macros shared by the checker modules of the RGB to HSV core.
// Assumes a clock named aclk and an active-low reset named aresetn in scope.
`ifndef RGB_TO_HSV_PIXEL_CORE_ASSERT_SVH
`define RGB_TO_HSV_PIXEL_CORE_ASSERT_SVH

// Same-cycle implication, checked on every rising edge out of reset.
`define R2H_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on every rising edge out of reset.
`define R2H_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/r2h_pkg.sv @@
// Package for the RGB to HSV pixel core: field widths, pipeline geometry
// and the radix-2 divider step. No dependencies.
`default_nettype none

package r2h_pkg;

    localparam int CH_W       = 8;    // input channel and brightness width
    localparam int HUE_W      = 16;   // Q0.16 hue
    localparam int SAT_W      = 17;   // Q1.16 saturation
    localparam int DIV_W      = 11;   // divisor and remainder width (6 * 255 < 2048)
    localparam int NUM_W      = 12;   // signed sector numerator width
    localparam int STEP_BITS  = 4;    // quotient bits resolved per stage
    localparam int DIV_STAGES = HUE_W / STEP_BITS;
    localparam int NUM_STAGES = DIV_STAGES + 1;   // front stage plus divider stages

    // One item as it travels down the pipeline.
    typedef struct packed {
        logic [CH_W-1:0]  brightness;
        logic [DIV_W-1:0] hue_rem;
        logic [DIV_W-1:0] hue_div;
        logic [HUE_W-1:0] hue_q;
        logic [DIV_W-1:0] sat_rem;
        logic [DIV_W-1:0] sat_div;
        logic [SAT_W-1:0] sat_q;
    } lane_t;

    typedef struct packed {
        logic [DIV_W-1:0]     rem;
        logic [STEP_BITS-1:0] q;
    } div_step_t;

    // Restoring division steps: rem < div on entry and on exit.
    function automatic div_step_t div_steps(input logic [DIV_W-1:0] rem,
                                            input logic [DIV_W-1:0] div);
        logic [DIV_W:0]   rem_w;
        logic [DIV_W-1:0] r;
        div_step_t        res;
        r = rem;
        res.q = '0;
        for (int i = STEP_BITS - 1; i >= 0; i--) begin
            rem_w = {r, 1'b0};
            if (rem_w >= {1'b0, div}) begin
                res.q[i] = 1'b1;
                rem_w    = rem_w - {1'b0, div};
            end
            r = rem_w[DIV_W-1:0];
        end
        res.rem = r;
        return res;
    endfunction

endpackage

`default_nettype wire

@@ sv/rgb_to_hsv_pixel_core.sv @@
// RGB to HSV pixel converter, top level.
// Depends on r2h_pkg (widths, lane type, divider step function).
// Converts one 8-bit RGB pixel per clock into hue (Q0.16 turn, truncated),
// saturation (chroma/value in Q1.16, truncated) and brightness (largest
// channel). Input acceptance loads a front stage that finds max, min, chroma
// and the hue sector numerator, then four divider stages each resolve four
// quotient bits of both divisions (chroma/value and numerator/(6*chroma)).
// Throughput is one item per clock while the output is not stalled; each
// stage holds its item only while the stage ahead is full and stalled, so
// bubbles collapse and input is taken while a result waits.
// Black pixels give zero saturation and hue, grey pixels give zero hue; on ties
// for the largest channel red wins over green and green over blue.
`default_nettype none

module rgb_to_hsv_pixel_core (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [r2h_pkg::CH_W-1:0]   s_red,
    input  logic [r2h_pkg::CH_W-1:0]   s_green,
    input  logic [r2h_pkg::CH_W-1:0]   s_blue,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [r2h_pkg::HUE_W-1:0]  m_hue,
    output logic [r2h_pkg::SAT_W-1:0]  m_saturation,
    output logic [r2h_pkg::CH_W-1:0]   m_brightness
);
    import r2h_pkg::*;

    lane_t                 pipe_reg [NUM_STAGES];
    lane_t                 pipe_next[NUM_STAGES];
    logic [NUM_STAGES-1:0] vld_reg;
    logic [NUM_STAGES-1:0] vld_next;
    logic [NUM_STAGES-1:0] adv;

    logic [CH_W-1:0]         mx;
    logic [CH_W-1:0]         mn;
    logic [CH_W-1:0]         chroma;
    logic [DIV_W-1:0]        six_c;
    logic signed [NUM_W-1:0] num;
    lane_t                   front;

    // A stage advances when it is empty or the stage ahead advances.
    always_comb begin
        adv[NUM_STAGES-1] = !vld_reg[NUM_STAGES-1] || m_ready;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            adv[k] = !vld_reg[k] || adv[k+1];
        end
    end

    assign s_ready = adv[0];

    // Front stage: value, chroma, sector numerator and divider setup.
    always_comb begin
        mx = s_red;
        if (s_green > mx) begin
            mx = s_green;
        end
        if (s_blue > mx) begin
            mx = s_blue;
        end
        mn = s_red;
        if (s_green < mn) begin
            mn = s_green;
        end
        if (s_blue < mn) begin
            mn = s_blue;
        end
        chroma = mx - mn;
        six_c  = DIV_W'({chroma, 2'b00}) + DIV_W'({chroma, 1'b0});

        if (mx == s_red) begin
            num = $signed({4'b0000, s_green}) - $signed({4'b0000, s_blue});
        end else if (mx == s_green) begin
            num = $signed({4'b0000, s_blue}) - $signed({4'b0000, s_red})
                + $signed({3'b000, chroma, 1'b0});
        end else begin
            num = $signed({4'b0000, s_red}) - $signed({4'b0000, s_green})
                + $signed({2'b00, chroma, 2'b00});
        end
        // Wrap a negative sector result into the full turn.
        if (num < 0) begin
            num = num + $signed({1'b0, six_c});
        end

        front.brightness = mx;
        front.hue_q      = '0;
        // Grey pixel: divide zero by one so the hue comes out zero.
        if (chroma == '0) begin
            front.hue_rem = '0;
            front.hue_div = DIV_W'(1);
        end else begin
            front.hue_rem = num[DIV_W-1:0];
            front.hue_div = six_c;
        end
        // Black pixel: divide zero by one so the saturation comes out zero.
        if (mx == '0) begin
            front.sat_div = DIV_W'(1);
            front.sat_rem = '0;
            front.sat_q   = '0;
        end else if (chroma == mx) begin
            front.sat_div = DIV_W'(mx);
            front.sat_rem = '0;
            front.sat_q   = SAT_W'(1);
        end else begin
            front.sat_div = DIV_W'(mx);
            front.sat_rem = DIV_W'(chroma);
            front.sat_q   = '0;
        end
    end

    // Divider stages: four quotient bits of each division per stage.
    always_comb begin
        div_step_t hs;
        div_step_t ss;
        pipe_next[0] = front;
        vld_next[0]  = s_valid;
        for (int k = 1; k < NUM_STAGES; k++) begin
            hs = div_steps(pipe_reg[k-1].hue_rem, pipe_reg[k-1].hue_div);
            ss = div_steps(pipe_reg[k-1].sat_rem, pipe_reg[k-1].sat_div);
            pipe_next[k]         = pipe_reg[k-1];
            pipe_next[k].hue_rem = hs.rem;
            pipe_next[k].hue_q   = {pipe_reg[k-1].hue_q[HUE_W-STEP_BITS-1:0], hs.q};
            pipe_next[k].sat_rem = ss.rem;
            pipe_next[k].sat_q   = {pipe_reg[k-1].sat_q[SAT_W-STEP_BITS-1:0], ss.q};
            vld_next[k]          = vld_reg[k-1];
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < NUM_STAGES; k++) begin
            if (adv[k]) begin
                pipe_reg[k] <= pipe_next[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            for (int k = 0; k < NUM_STAGES; k++) begin
                if (adv[k]) begin
                    vld_reg[k] <= vld_next[k];
                end
            end
        end
    end

    assign m_valid      = vld_reg[NUM_STAGES-1];
    assign m_hue        = pipe_reg[NUM_STAGES-1].hue_q;
    assign m_saturation = pipe_reg[NUM_STAGES-1].sat_q;
    assign m_brightness = pipe_reg[NUM_STAGES-1].brightness;

endmodule

`default_nettype wire

@@ sv/r2h_checker.sv @@
// Port-level checker for rgb_to_hsv_pixel_core, bound to the top level.
// Depends on r2h_pkg and the macros in rgb_to_hsv_pixel_core_assert.svh.
`default_nettype none

`include "rgb_to_hsv_pixel_core_assert.svh"

module r2h_checker (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       s_ready,
    input logic                       m_valid,
    input logic                       m_ready,
    input logic [r2h_pkg::HUE_W-1:0]  m_hue,
    input logic [r2h_pkg::SAT_W-1:0]  m_saturation,
    input logic [r2h_pkg::CH_W-1:0]   m_brightness
);
    import r2h_pkg::*;

    // A stalled result holds its payload.
    `R2H_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_hue) && $stable(m_saturation) && $stable(m_brightness), "stalled result changed")

    // With no result pending the pipeline has room for a new item.
    `R2H_ASSERT_NOW(a_ready_when_drained, !m_valid, s_ready, "input blocked with empty output")

    // Black pixel: no saturation and no hue.
    `R2H_ASSERT_NOW(a_black, m_valid && m_brightness == '0, m_saturation == '0 && m_hue == '0, "black pixel with nonzero hue or saturation")

    // Saturation never exceeds one, and zero saturation means zero hue.
    `R2H_ASSERT_NOW(a_sat_range, m_valid, m_saturation <= SAT_W'(65536) && (m_saturation != '0 || m_hue == '0), "saturation out of range or grey hue nonzero")

endmodule

bind rgb_to_hsv_pixel_core r2h_checker u_r2h_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_hue        (m_hue),
    .m_saturation (m_saturation),
    .m_brightness (m_brightness)
);

`default_nettype wire

@@ verif/tb_rgb_to_hsv_pixel_core.sv @@
// Self-checking testbench for rgb_to_hsv_pixel_core: a queue-fed pixel driver,
// a result monitor and a bit-exact HSV predictor.
// Depends on r2h_pkg for the field widths and on the core itself.
`default_nettype none

module tb_rgb_to_hsv_pixel_core;

    timeunit 1ns;
    timeprecision 1ps;

    import r2h_pkg::*;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } pixel_t;

    typedef struct packed {
        logic [HUE_W-1:0] hue;
        logic [SAT_W-1:0] saturation;
        logic [CH_W-1:0]  brightness;
    } hsv_t;

    localparam int RANDOM_PIXELS = 1300;
    localparam int CALM_START    = 500;   // cycle window with no idling on either side
    localparam int CALM_STOP     = 900;
    localparam int DRAIN_CYCLES  = 12;

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    logic [CH_W-1:0]     s_red;
    logic [CH_W-1:0]     s_green;
    logic [CH_W-1:0]     s_blue;
    logic                m_valid;
    logic                m_ready;
    logic [HUE_W-1:0]    m_hue;
    logic [SAT_W-1:0]    m_saturation;
    logic [CH_W-1:0]     m_brightness;

    pixel_t pending_px[$];
    hsv_t   hsv_q[$];
    int     cycle_cnt;
    int     px_sent;
    int     px_checked;
    int     grey_cnt;
    int     mismatch_cnt;
    logic   calm;

    rgb_to_hsv_pixel_core i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_red        (s_red),
        .s_green      (s_green),
        .s_blue       (s_blue),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_hue        (m_hue),
        .m_saturation (m_saturation),
        .m_brightness (m_brightness)
    );

    initial aclk = 1'b0;
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Bit-exact HSV of one pixel: six-sector hue, truncated fixed-point divisions.
    function automatic hsv_t hsv_of(input logic [CH_W-1:0] r, input logic [CH_W-1:0] g,
                                    input logic [CH_W-1:0] b);
        int   rv, gv, bv, top, bot, chroma, num;
        hsv_t res;
        rv     = int'(r);
        gv     = int'(g);
        bv     = int'(b);
        top    = (rv > gv) ? rv : gv;
        top    = (top > bv) ? top : bv;
        bot    = (rv < gv) ? rv : gv;
        bot    = (bot < bv) ? bot : bv;
        chroma = 0;
        res    = '0;
        res.brightness = top[CH_W-1:0];
        if (top != 0) begin
            chroma         = top - bot;
            res.saturation = SAT_W'((chroma * 65536) / top);
        end
        if (chroma != 0) begin
            // red wins ties over green, green over blue
            if (top == rv)
                num = gv - bv;
            else if (top == gv)
                num = bv - rv + 2 * chroma;
            else
                num = rv - gv + 4 * chroma;
            if (num < 0)
                num += 6 * chroma;
            res.hue = HUE_W'((num * 65536) / (6 * chroma));
        end
        return res;
    endfunction

    task automatic note_mismatch(input string what);
        $display("[%0t] MISMATCH: %s", $realtime, what);
        mismatch_cnt++;
    endtask

    task automatic add_pixel(input int r, input int g, input int b);
        pixel_t px;
        px.red   = r[CH_W-1:0];
        px.green = g[CH_W-1:0];
        px.blue  = b[CH_W-1:0];
        if (px.red == px.green && px.green == px.blue)
            grey_cnt++;
        pending_px.push_back(px);
    endtask

    always @(posedge aclk) begin
        if (!aresetn)
            cycle_cnt <= 0;
        else
            cycle_cnt <= cycle_cnt + 1;
    end

    assign calm = (cycle_cnt >= CALM_START) && (cycle_cnt < CALM_STOP);

    // Pixel driver: record the accepted item, then present the next one or idle.
    always @(posedge aclk) begin : pixel_drive
        pixel_t nxt;
        logic   load;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                hsv_q.push_back(hsv_of(s_red, s_green, s_blue));
                px_sent++;
            end
            if (!s_valid || s_ready) begin
                load = (pending_px.size() > 0) && (calm || $urandom_range(0, 99) >= 10);
                if (load) begin
                    nxt = pending_px.pop_front();
                    s_red   <= nxt.red;
                    s_green <= nxt.green;
                    s_blue  <= nxt.blue;
                end
                s_valid <= load;
            end
        end
    end

    // Result monitor: compare each accepted item with the oldest expectation.
    always @(posedge aclk) begin : result_check
        hsv_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (hsv_q.size() == 0) begin
                    note_mismatch($sformatf("unexpected item hue=%0d sat=%0d val=%0d",
                                            m_hue, m_saturation, m_brightness));
                end else begin
                    want = hsv_q.pop_front();
                    if (m_hue !== want.hue)
                        note_mismatch($sformatf("item %0d hue %0d, want %0d",
                                                px_checked, m_hue, want.hue));
                    if (m_saturation !== want.saturation)
                        note_mismatch($sformatf("item %0d saturation %0d, want %0d",
                                                px_checked, m_saturation, want.saturation));
                    if (m_brightness !== want.brightness)
                        note_mismatch($sformatf("item %0d brightness %0d, want %0d",
                                                px_checked, m_brightness, want.brightness));
                    px_checked++;
                end
            end
            m_ready <= calm || ($urandom_range(0, 99) >= 10);
        end
    end

    initial begin : stimulus
        int sel, lvl, a, b;
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_red        = '0;
        s_green      = '0;
        s_blue       = '0;
        m_ready      = 1'b0;
        px_sent      = 0;
        px_checked   = 0;
        grey_cnt     = 0;
        mismatch_cnt = 0;

        // directed corners: black, white, greys, primaries, ties, hue wrap, full saturation
        add_pixel(0, 0, 0);
        add_pixel(255, 255, 255);
        add_pixel(1, 1, 1);
        add_pixel(128, 128, 128);
        add_pixel(255, 0, 0);
        add_pixel(0, 255, 0);
        add_pixel(0, 0, 255);
        add_pixel(255, 255, 0);
        add_pixel(0, 255, 255);
        add_pixel(255, 0, 255);
        add_pixel(255, 0, 128);
        add_pixel(255, 128, 0);
        add_pixel(0, 128, 255);
        add_pixel(128, 255, 0);
        add_pixel(200, 0, 50);
        add_pixel(1, 0, 0);
        add_pixel(1, 1, 0);
        add_pixel(0, 0, 1);
        add_pixel(255, 254, 255);
        add_pixel(254, 255, 253);
        add_pixel(255, 1, 0);
        add_pixel(170, 85, 85);
        add_pixel(255, 255, 254);

        for (int i = 0; i < RANDOM_PIXELS; i++) begin
            sel = $urandom_range(0, 99);
            if (sel < 65) begin
                add_pixel($urandom_range(0, 255), $urandom_range(0, 255),
                          $urandom_range(0, 255));
            end else if (sel < 75) begin
                lvl = $urandom_range(0, 255);
                add_pixel(lvl, lvl, lvl);
            end else if (sel < 88) begin
                // two channels tie, the third random
                a = $urandom_range(0, 255);
                b = $urandom_range(0, 255);
                case ($urandom_range(0, 2))
                    0: add_pixel(a, a, b);
                    1: add_pixel(a, b, a);
                    default: add_pixel(b, a, a);
                endcase
            end else begin
                // pin channels to the rails
                add_pixel(($urandom_range(0, 1) != 0) ? 255 : $urandom_range(0, 255),
                          ($urandom_range(0, 1) != 0) ? 0 : $urandom_range(0, 255),
                          ($urandom_range(0, 2) == 0) ? 255 : $urandom_range(0, 255));
            end
        end

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_px.size() > 0 || s_valid || hsv_q.size() > 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (hsv_q.size() > 0)
            note_mismatch($sformatf("%0d expected items never arrived", hsv_q.size()));
        $display("Converted %0d pixels (%0d grey or black), %0d results compared, %0d mismatches",
                 px_sent, grey_cnt, px_checked, mismatch_cnt);
        if (mismatch_cnt == 0)
            $display("rgb_to_hsv_pixel_core test passed");
        else
            $display("rgb_to_hsv_pixel_core test failed");
        $finish;
    end

    initial begin : watchdog
        #2_000_000;
        $display("Timeout with %0d pixels queued and %0d results outstanding",
                 pending_px.size(), hsv_q.size());
        $display("rgb_to_hsv_pixel_core test failed");
        $finish;
    end

endmodule

`default_nettype wire
